/* sv/iira_pkg.sv */
// Package for the indexed insert/remove array: sizes, field types, codes
// and the control structs passed between the controller and the cell row.
// No dependencies.
package iira_pkg;

	// Storage sizing.
	localparam int CAPACITY    = 64;
	localparam int ENTRY_WIDTH = 32;

	// Fixed widths of the transaction fields.
	localparam int TYPE_FW   = 3;
	localparam int IDX_FW    = 7;
	localparam int WORD_FW   = 32;
	localparam int LEN_FW    = 7;
	localparam int CAP_FW    = 7;

	// Derived internal widths.
	localparam int POS_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > IDX_FW) ? CNT_W : IDX_FW;

	// Read-out tree: cells are ORed in groups, one register per group.
	localparam int RD_GROUP  = 8;
	localparam int RD_GROUPS = (CAPACITY + RD_GROUP - 1) / RD_GROUP;

	typedef logic [TYPE_FW-1:0] rtype_t;
	typedef logic [IDX_FW-1:0]  fidx_t;
	typedef logic [WORD_FW-1:0] word_t;
	typedef logic [LEN_FW-1:0]  len_t;
	typedef logic [CAP_FW-1:0]  cap_t;
	typedef logic [ENTRY_WIDTH-1:0] entry_t;
	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [CMP_W-1:0]   cmp_t;
	typedef logic [CMP_W:0]     cmp1_t;

	localparam cap_t CAP_RESET = cap_t'(64);

	// Request codes.
	typedef enum logic [TYPE_FW-1:0] {
		REQ_APPEND = 3'd0,
		REQ_INSERT = 3'd1,
		REQ_REMOVE = 3'd2,
		REQ_SLICE  = 3'd3,
		REQ_READ   = 3'd4,
		REQ_WRITE  = 3'd5
	} req_t;

	// Response status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Commands broadcast to the cell row.
	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_INSERT,
		CMD_REMOVE,
		CMD_WRITE
	} cell_cmd_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SLICE,
		S_READ,
		S_FIN
	} state_t;

	typedef struct packed {
		cell_cmd_t cmd;
		pos_t      pos;
		entry_t    word;
	} cell_ctl_t;

	typedef struct packed {
		state_t state;
		cnt_t   count;
	} iira_stat_t;

endpackage

/* sv/iira_req_if.sv */
// Request channel: valid/ready handshake with the request fields.
// Depends on iira_pkg.
interface iira_req_if import iira_pkg::*; ();
	logic   valid;
	logic   ready;
	rtype_t req_type;
	fidx_t  index;
	fidx_t  slice_end;
	word_t  value;

	modport source (output valid, req_type, index, slice_end, value, input ready);
	modport sink (input valid, req_type, index, slice_end, value, output ready);
endinterface

/* sv/iira_rsp_if.sv */
// Response channel: valid/ready handshake with status, read word and length.
// Depends on iira_pkg.
interface iira_rsp_if import iira_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	word_t   read_value;
	len_t    length;

	modport source (output valid, status, read_value, length, input ready);
	modport sink (input valid, status, read_value, length, output ready);
endinterface

/* sv/iira_cfg_if.sv */
// Configuration write channel carrying the capacity limit register.
// Depends on iira_pkg.
interface iira_cfg_if import iira_pkg::*; ();
	logic valid;
	logic ready;
	cap_t capacity_limit;

	modport source (output valid, capacity_limit, input ready);
	modport sink (input valid, capacity_limit, output ready);
endinterface

/* sv/iira_cell.sv */
// One storage cell of the array row. It holds one entry and, on a broadcast
// command, loads from its left or right neighbor or from the command word.
// Depends on iira_pkg.
module iira_cell import iira_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  pos_t      my_pos,
	input  entry_t    left_word,
	input  entry_t    right_word,
	output entry_t    word,
	output entry_t    hit_word
);

	entry_t word_q;

	// Shift up on insert, shift down on remove, load on a positional match.
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_INSERT: begin
				if (my_pos > ctl.pos) begin
					word_q <= left_word;
				end else if (my_pos == ctl.pos) begin
					word_q <= ctl.word;
				end
			end
			CMD_REMOVE: begin
				if (my_pos >= ctl.pos) begin
					word_q <= right_word;
				end
			end
			CMD_WRITE: begin
				if (my_pos == ctl.pos) begin
					word_q <= ctl.word;
				end
			end
			default: begin
			end
		endcase
	end

	assign word = word_q;

	// Only the addressed cell contributes to the read-out tree.
	assign hit_word = (my_pos == ctl.pos) ? word_q : '0;

endmodule

/* sv/iira_rd_tree.sv */
// Registered OR tree that gathers the addressed cell's word for a read.
// Groups of cells are ORed into registers, then the groups are ORed.
// Depends on iira_pkg.
module iira_rd_tree import iira_pkg::*; (
	input  logic   clk,
	input  entry_t hit_words [CAPACITY],
	output entry_t rd_word
);

	entry_t grp_d  [RD_GROUPS];
	entry_t grp_s1 [RD_GROUPS];

	// First level: OR each group of cells.
	always_comb begin
		for (int g = 0; g < RD_GROUPS; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < RD_GROUP; k++) begin
				if (g * RD_GROUP + k < CAPACITY) begin
					grp_d[g] = grp_d[g] | hit_words[g * RD_GROUP + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_d;
	end

	// Second level: OR the registered groups.
	always_comb begin
		rd_word = '0;
		for (int g = 0; g < RD_GROUPS; g++) begin
			rd_word = rd_word | grp_s1[g];
		end
	end

endmodule

/* sv/iira_ctrl.sv */
// Controller: request capture, range and fullness checks, cell commands,
// slice sequencing, length and limit registers and the response register.
// Depends on iira_pkg and the three channel interfaces.
module iira_ctrl import iira_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	iira_req_if.sink    req,
	iira_rsp_if.source  rsp,
	iira_cfg_if.sink    cfg,
	input  entry_t      rd_word,
	output cell_ctl_t   ctl,
	output iira_stat_t  stat
);

	state_t  state_q, state_d;
	rtype_t  type_q;
	fidx_t   index_q;
	fidx_t   send_q;
	word_t   value_q;
	cnt_t    count_q, count_d;
	cnt_t    left_q, left_d;
	cap_t    cap_q;
	status_t res_status_q;
	word_t   res_rd_q;
	logic    out_valid_q;
	status_t out_status_q;
	word_t   out_rd_q;
	len_t    out_len_q;

	logic      slot_free;
	logic      fin;
	status_t   fin_status;
	word_t     fin_rd;
	cell_cmd_t cmd;
	cmp_t      idx, cnt, lim;
	cmp1_t     end_v, span;
	logic      rem_ok, in_range;

	// Operand views widened to a common compare width.
	assign idx      = cmp_t'(index_q);
	assign cnt      = cmp_t'(count_q);
	assign lim      = (cmp_t'(cap_q) < cmp_t'(CAPACITY)) ? cmp_t'(cap_q) : cmp_t'(CAPACITY);
	assign end_v    = (type_q == REQ_REMOVE) ? (cmp1_t'(idx) + cmp1_t'(1)) : cmp1_t'(send_q);
	assign span     = end_v - cmp1_t'(idx);
	assign rem_ok   = (cmp1_t'(idx) < end_v) && (end_v <= cmp1_t'(cnt));
	assign in_range = idx < cnt;

	assign slot_free = !out_valid_q || rsp.ready;

	// Next state, cell command and result of the current transaction.
	always_comb begin
		state_d    = state_q;
		cmd        = CMD_NONE;
		count_d    = count_q;
		left_d     = left_q;
		fin        = 1'b0;
		fin_status = ST_OK;
		fin_rd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (type_q)
					REQ_APPEND, REQ_INSERT: begin
						fin = 1'b1;
						if (type_q == REQ_INSERT && idx > cnt) begin
							fin_status = ST_RANGE;
						end else if (cnt >= lim) begin
							fin_status = ST_FULL;
						end else begin
							cmd     = CMD_INSERT;
							count_d = count_q + cnt_t'(1);
						end
					end
					REQ_REMOVE, REQ_SLICE: begin
						if (!rem_ok) begin
							fin        = 1'b1;
							fin_status = ST_RANGE;
						end else begin
							cmd     = CMD_REMOVE;
							count_d = count_q - cnt_t'(span);
							if (span == cmp1_t'(1)) begin
								fin = 1'b1;
							end else begin
								left_d  = cnt_t'(span - cmp1_t'(1));
								state_d = S_SLICE;
							end
						end
					end
					REQ_READ: begin
						if (in_range) begin
							state_d = S_READ;
						end else begin
							fin        = 1'b1;
							fin_status = ST_RANGE;
						end
					end
					REQ_WRITE: begin
						fin = 1'b1;
						if (in_range) begin
							cmd = CMD_WRITE;
						end else begin
							fin_status = ST_RANGE;
						end
					end
					default: begin
						fin        = 1'b1;
						fin_status = ST_RANGE;
					end
				endcase
			end
			S_SLICE: begin
				cmd    = CMD_REMOVE;
				left_d = left_q - cnt_t'(1);
				if (left_q == cnt_t'(1)) begin
					fin = 1'b1;
				end
			end
			S_READ: begin
				fin    = 1'b1;
				fin_rd = word_t'(rd_word);
			end
			S_FIN: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = slot_free ? S_IDLE : S_FIN;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			left_q      <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			left_q  <= left_d;
			if (cfg.valid) begin
				cap_q <= cfg.capacity_limit;
			end
			if ((fin || state_q == S_FIN) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request capture, parked result and response payload.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			type_q  <= req.req_type;
			index_q <= req.index;
			send_q  <= req.slice_end;
			value_q <= req.value;
		end
		if (fin && !slot_free) begin
			res_status_q <= fin_status;
			res_rd_q     <= fin_rd;
		end
		if (fin && slot_free) begin
			out_status_q <= fin_status;
			out_rd_q     <= fin_rd;
			out_len_q    <= len_t'(count_d);
		end else if (state_q == S_FIN && slot_free) begin
			out_status_q <= res_status_q;
			out_rd_q     <= res_rd_q;
			out_len_q    <= len_t'(count_q);
		end
	end

	assign req.ready      = (state_q == S_IDLE);
	assign cfg.ready      = 1'b1;
	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.read_value = out_rd_q;
	assign rsp.length     = out_len_q;

	assign ctl.cmd  = cmd;
	assign ctl.pos  = (type_q == REQ_APPEND) ? pos_t'(count_q) : pos_t'(index_q);
	assign ctl.word = entry_t'(value_q);

	assign stat.state = state_q;
	assign stat.count = count_q;

endmodule

/* sv/indexed_insert_remove_array.sv */
// Top level of the indexed insert/remove array: controller, cell row and
// read-out tree. Depends on iira_pkg, the channel interfaces and all iira_ modules.
//
// Usage:
//   req carries one request per transaction (append, insert, remove, remove
//   slice, read, write); rsp returns one transaction per request with the
//   status, the read word and the length after the request. cfg writes the
//   capacity limit and is always ready; write it only while the block is idle.
//   A request is taken in the idle state only, so one request is in flight.
//   Append, insert, remove, write and any rejected request finish in the
//   execute state; a read finishes in the read state, after one register in
//   the read-out tree; remove slice shifts the cell row down by one position
//   per cycle until the whole slice is gone. The block returns to idle as the
//   response is registered, so the next request can be taken while it waits.
//   When the receiver stalls, the response waits in the output register and
//   the next request is still accepted; its result is parked until the
//   output register frees, and the block takes nothing more meanwhile.
//   Reset clears the length to zero and sets the limit to 64; entry contents
//   are undefined until written and need no clearing.
module indexed_insert_remove_array import iira_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	iira_req_if.sink   req,
	iira_rsp_if.source rsp,
	iira_cfg_if.sink   cfg
);

	cell_ctl_t  ctl;
	iira_stat_t stat;
	entry_t     rd_word;
	entry_t     words     [CAPACITY];
	entry_t     hit_words [CAPACITY];

	iira_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.cfg     (cfg),
		.rd_word (rd_word),
		.ctl     (ctl),
		.stat    (stat)
	);

	// Row of cells; each cell sees its two neighbors.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = words[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = words[i+1];
		end
		iira_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.my_pos     (pos_t'(i)),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (words[i]),
			.hit_word   (hit_words[i])
		);
	end

	iira_rd_tree u_rd_tree (
		.clk       (clk),
		.hit_words (hit_words),
		.rd_word   (rd_word)
	);

	// Only one request is in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while another is in flight");

	// The cell row is only commanded while a request executes.
	a_cmd_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.cmd != CMD_NONE) |-> (stat.state == S_EXEC || stat.state == S_SLICE))
		else $error("cell command outside execution");

	// The length never passes the storage size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= cnt_t'(CAPACITY))
		else $error("length exceeds capacity");

endmodule

/* test/indexed_insert_remove_array_test.sv */
// Self-checking testbench for indexed_insert_remove_array: a directed table
// and random phases, checked against a behavioral array model kept in sync.
// Depends on iira_pkg, the iira_ channel interfaces and the block itself.
module indexed_insert_remove_array_test import iira_pkg::*;;

	localparam int MAX_CYCLES   = 1000000;
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASE_ITEMS  = 230;
	localparam int NUM_PHASES   = 8;
	localparam int PHASE_LIMITS [NUM_PHASES] = '{64, 127, 1, 17, 0, 64, 40, 2};

	// Request codes the block does not define; both must be rejected.
	localparam rtype_t REQ_SPARE_A = 3'd6;
	localparam rtype_t REQ_SPARE_B = 3'd7;

	typedef struct packed {
		rtype_t req_type;
		fidx_t  index;
		fidx_t  slice_end;
		word_t  value;
	} array_op_t;

	typedef struct packed {
		status_t status;
		word_t   read_value;
		len_t    length;
	} array_rsp_t;

	typedef enum logic {ROW_OP, ROW_LIMIT} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		array_op_t  op;
		logic       typed;
		array_rsp_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	iira_req_if req_ch ();
	iira_rsp_if rsp_ch ();
	iira_cfg_if cfg_ch ();

	indexed_insert_remove_array dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source),
		.cfg    (cfg_ch.sink)
	);

	// Shadow copy of the array contents, length and limit.
	entry_t shadow_words [CAPACITY];
	len_t   shadow_len = '0;
	cap_t   shadow_limit = CAP_RESET;

	array_rsp_t pending_rsps [$];
	int mismatches = 0;
	int rsp_count = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit growing = 1'b1;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int effective_limit();
		return (int'(shadow_limit) < CAPACITY) ? int'(shadow_limit) : CAPACITY;
	endfunction

	// The position is checked before fullness, as the block does.
	function automatic status_t shadow_insert(int pos, word_t w);
		if (pos > int'(shadow_len))
			return ST_RANGE;
		if (int'(shadow_len) >= effective_limit())
			return ST_FULL;
		for (int i = int'(shadow_len); i > pos; i--)
			shadow_words[i] = shadow_words[i - 1];
		shadow_words[pos] = w;
		shadow_len = len_t'(int'(shadow_len) + 1);
		return ST_OK;
	endfunction

	// Removes the span [start, stop) and closes the gap.
	function automatic status_t shadow_remove(int start, int stop);
		int span;
		if (!(start < stop && stop <= int'(shadow_len)))
			return ST_RANGE;
		span = stop - start;
		for (int i = start; i + span < int'(shadow_len); i++)
			shadow_words[i] = shadow_words[i + span];
		shadow_len = len_t'(int'(shadow_len) - span);
		return ST_OK;
	endfunction

	// Applies one request to the shadow array and returns its response.
	function automatic array_rsp_t predict_array_op(array_op_t op);
		array_rsp_t r;
		int idx;
		idx = int'(op.index);
		r.read_value = '0;
		case (op.req_type)
			REQ_APPEND: r.status = shadow_insert(int'(shadow_len), op.value);
			REQ_INSERT: r.status = shadow_insert(idx, op.value);
			REQ_REMOVE: r.status = shadow_remove(idx, idx + 1);
			REQ_SLICE:  r.status = shadow_remove(idx, int'(op.slice_end));
			REQ_READ: begin
				if (idx < int'(shadow_len)) begin
					r.read_value = shadow_words[idx];
					r.status = ST_OK;
				end else begin
					r.status = ST_RANGE;
				end
			end
			REQ_WRITE: begin
				if (idx < int'(shadow_len)) begin
					shadow_words[idx] = op.value;
					r.status = ST_OK;
				end else begin
					r.status = ST_RANGE;
				end
			end
			default: r.status = ST_RANGE;
		endcase
		r.length = shadow_len;
		return r;
	endfunction

	// Mostly a valid position below len + slack, sometimes one at or past it.
	function automatic fidx_t pick_index(int len, int slack);
		int top;
		top = len - 1 + slack;
		if (top < 0 || $urandom_range(9) == 0)
			return fidx_t'($urandom_range(127, top + 1));
		return fidx_t'($urandom_range(top));
	endfunction

	// Well-formed requests with random content, plus a little noise.
	function automatic array_op_t random_array_op();
		array_op_t op;
		int len;
		int roll;
		int start;
		int stop;
		len = int'(shadow_len);
		op.index = fidx_t'($urandom_range(127));
		op.slice_end = fidx_t'($urandom_range(127));
		roll = $urandom_range(15);
		op.value = (roll == 0) ? '0 : (roll == 1) ? '1 : word_t'($urandom);
		if ($urandom_range(99) < 8) begin
			op.req_type = rtype_t'($urandom_range(7));
			return op;
		end
		roll = $urandom_range(99);
		if (roll < (growing ? 60 : 20)) begin
			if ($urandom_range(1) == 0) begin
				op.req_type = REQ_APPEND;
			end else begin
				op.req_type = REQ_INSERT;
				op.index = pick_index(len, 1);
			end
		end else if (roll < (growing ? 75 : 65)) begin
			if ($urandom_range(9) < 7) begin
				op.req_type = REQ_REMOVE;
				op.index = pick_index(len, 0);
			end else begin
				op.req_type = REQ_SLICE;
				start = (len > 0) ? int'($urandom_range(len - 1)) : 0;
				roll = $urandom_range(9);
				if (roll == 0) begin
					stop = len;
				end else if (roll == 1) begin
					// Empty or reversed slice.
					stop = $urandom_range(start);
				end else if (roll == 2) begin
					stop = len + 1;
				end else begin
					stop = start + int'($urandom_range(4, 1));
					if (stop > len)
						stop = len;
				end
				op.index = fidx_t'(start);
				op.slice_end = fidx_t'(stop);
			end
		end else begin
			op.req_type = ($urandom_range(1) == 0) ? REQ_READ : REQ_WRITE;
			op.index = pick_index(len, 0);
		end
		return op;
	endfunction

	function automatic plan_row_t op_row(rtype_t t, fidx_t i, fidx_t e, word_t v);
		plan_row_t row;
		row = '0;
		row.kind = ROW_OP;
		row.op = '{t, i, e, v};
		return row;
	endfunction

	function automatic plan_row_t op_row_chk(rtype_t t, fidx_t i, fidx_t e, word_t v,
			status_t s, word_t rv, len_t l);
		plan_row_t row;
		row = op_row(t, i, e, v);
		row.typed = 1'b1;
		row.want = '{s, rv, l};
		return row;
	endfunction

	function automatic plan_row_t limit_row(cap_t lim);
		plan_row_t row;
		row = '0;
		row.kind = ROW_LIMIT;
		row.op.value = word_t'(lim);
		return row;
	endfunction

	// Drives one request and returns at the edge where it is accepted.
	task automatic push_request(array_op_t op);
		if ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= op.req_type;
		req_ch.index <= op.index;
		req_ch.slice_end <= op.slice_end;
		req_ch.value <= op.value;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic wait_all_responses();
		req_ch.valid <= 1'b0;
		while (pending_rsps.size() != 0)
			@(posedge clk);
	endtask

	// The limit is only written once the block has gone idle.
	task automatic write_limit(cap_t lim);
		wait_all_responses();
		cfg_ch.valid <= 1'b1;
		cfg_ch.capacity_limit <= lim;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		shadow_limit = lim;
	endtask

	function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("response %0d: %s expected %0h, got %0h", rsp_count, field, want, got);
	endfunction

	// Receiver side: ready toggles at random according to the phase.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Each response transaction is checked against the oldest expectation.
	always @(posedge clk) begin
		array_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("response %0d arrived with nothing outstanding", rsp_count);
			end else begin
				want = pending_rsps.pop_front();
				if (rsp_ch.status !== want.status)
					note_mismatch("status", 32'(want.status), 32'(rsp_ch.status));
				if (rsp_ch.read_value !== want.read_value)
					note_mismatch("read_value", want.read_value, rsp_ch.read_value);
				if (rsp_ch.length !== want.length)
					note_mismatch("length", 32'(want.length), 32'(rsp_ch.length));
			end
			rsp_count++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == MAX_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		plan_row_t plan [$];
		array_op_t op;
		array_rsp_t predicted;

		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_APPEND;
		req_ch.index <= '0;
		req_ch.slice_end <= '0;
		req_ch.value <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.capacity_limit <= CAP_RESET;
		for (int i = 0; i < CAPACITY; i++)
			shadow_words[i] = '0;

		// Directed table: empty array, range edges, spare codes, full limits.
		plan.push_back(op_row_chk(REQ_READ, 0, 0, 0, ST_RANGE, 0, 0));
		plan.push_back(op_row_chk(REQ_REMOVE, 0, 0, 0, ST_RANGE, 0, 0));
		plan.push_back(op_row_chk(REQ_SLICE, 0, 1, 0, ST_RANGE, 0, 0));
		plan.push_back(op_row_chk(REQ_APPEND, 0, 0, 32'hFFFF_FFFF, ST_OK, 0, 1));
		plan.push_back(op_row_chk(REQ_INSERT, 0, 0, 0, ST_OK, 0, 2));
		plan.push_back(op_row_chk(REQ_INSERT, 3, 0, 1, ST_RANGE, 0, 2));
		plan.push_back(op_row_chk(REQ_INSERT, 127, 127, 1, ST_RANGE, 0, 2));
		plan.push_back(op_row_chk(REQ_INSERT, 2, 0, 32'h0000_1234, ST_OK, 0, 3));
		plan.push_back(op_row(REQ_INSERT, 1, 0, 32'h0000_BEEF));
		plan.push_back(op_row_chk(REQ_READ, 0, 0, 0, ST_OK, 0, 4));
		plan.push_back(op_row(REQ_READ, 2, 0, 0));
		plan.push_back(op_row_chk(REQ_WRITE, 3, 0, 32'hA5A5_5A5A, ST_OK, 0, 4));
		plan.push_back(op_row_chk(REQ_WRITE, 4, 0, 1, ST_RANGE, 0, 4));
		plan.push_back(op_row_chk(REQ_READ, 127, 0, 0, ST_RANGE, 0, 4));
		plan.push_back(op_row(REQ_READ, 3, 0, 0));
		plan.push_back(op_row_chk(REQ_SPARE_A, 0, 0, 0, ST_RANGE, 0, 4));
		plan.push_back(op_row_chk(REQ_SPARE_B, 127, 127, 32'hFFFF_FFFF, ST_RANGE, 0, 4));
		plan.push_back(op_row_chk(REQ_SLICE, 1, 1, 0, ST_RANGE, 0, 4));
		plan.push_back(op_row_chk(REQ_SLICE, 2, 1, 0, ST_RANGE, 0, 4));
		plan.push_back(op_row_chk(REQ_SLICE, 0, 5, 0, ST_RANGE, 0, 4));
		// Limit lowered below the current length.
		plan.push_back(limit_row(2));
		plan.push_back(op_row_chk(REQ_APPEND, 0, 0, 7, ST_FULL, 0, 4));
		plan.push_back(op_row_chk(REQ_INSERT, 0, 0, 7, ST_FULL, 0, 4));
		plan.push_back(op_row_chk(REQ_INSERT, 5, 0, 7, ST_RANGE, 0, 4));
		plan.push_back(op_row_chk(REQ_REMOVE, 1, 0, 0, ST_OK, 0, 3));
		plan.push_back(op_row(REQ_READ, 1, 0, 0));
		plan.push_back(op_row_chk(REQ_SLICE, 0, 3, 0, ST_OK, 0, 0));
		// A limit of zero rejects every insert.
		plan.push_back(limit_row(0));
		plan.push_back(op_row_chk(REQ_APPEND, 0, 0, 9, ST_FULL, 0, 0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_LIMIT) begin
				write_limit(cap_t'(plan[i].op.value));
			end else begin
				push_request(plan[i].op);
				predicted = predict_array_op(plan[i].op);
				pending_rsps.push_back(plan[i].typed ? plan[i].want : predicted);
			end
		end

		// Random phases, each with its own limit and idling pattern.
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_limit(cap_t'(PHASE_LIMITS[p]));
			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 65;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 65;
				end
				default: begin
					idle_pct = 26;
					stall_pct = 26;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Halfway through, hold off until the block has answered everything.
				if (n == PHASE_ITEMS / 2)
					wait_all_responses();
				if (shadow_len == 0)
					growing = 1'b1;
				else if (int'(shadow_len) >= effective_limit() && $urandom_range(3) == 0)
					growing = 1'b0;
				else if ($urandom_range(79) == 0)
					growing = !growing;
				op = random_array_op();
				push_request(op);
				pending_rsps.push_back(predict_array_op(op));
			end
		end

		wait_all_responses();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_rsps.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/iira_pkg.sv
sv/iira_req_if.sv
sv/iira_rsp_if.sv
sv/iira_cfg_if.sv
sv/iira_cell.sv
sv/iira_rd_tree.sv
sv/iira_ctrl.sv
sv/indexed_insert_remove_array.sv
test/indexed_insert_remove_array_test.sv
